### src/gss_pkg.sv
// Package for the golden-section search core: formats, constants, control word and microcode ROM.
package gss_pkg;

   // Field widths and fixed-point formats.
   localparam int STEP_W      = 7;
   localparam int X_W         = 32;
   localparam int F_W         = 64;
   localparam int FRAC_BITS   = 28;
   localparam int F_FRAC      = 40;
   localparam int M40_SHIFT   = F_FRAC - FRAC_BITS;
   localparam int Q30_SHIFT   = 30;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 96;

   // Golden ratio constants in Q30.
   localparam logic [31:0] PHI_INV_Q30           = 32'd663608942;
   localparam logic [31:0] ONE_MINUS_PHI_INV_Q30 = 32'd410132882;

   localparam logic [63:0] ONE_Q40 = 64'd1 << F_FRAC;
   localparam logic [63:0] F_MAX   = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] F_MIN   = 64'h8000_0000_0000_0000;

   // Microprogram counter and entry points.
   localparam int UPC_W = 5;
   typedef logic [UPC_W-1:0] upc_type;

   localparam upc_type UPC_IDLE = 5'd0;
   localparam upc_type UPC_LOOP = 5'd1;
   localparam upc_type UPC_FIN  = 5'd9;
   localparam upc_type UPC_POLY = 5'd11;

   // Sequencing operations.
   typedef enum logic [2:0] {
      SEQ_NEXT,
      SEQ_JUMP,
      SEQ_JZ,
      SEQ_CALL,
      SEQ_RET,
      SEQ_WAIT_IN,
      SEQ_WAIT_OUT
   } seq_op_type;

   // Multiplier operand selects.
   typedef enum logic [1:0] {
      MA_DMAG,
      MA_U_LO,
      MA_U_HI
   } ma_sel_type;

   typedef enum logic [1:0] {
      MB_C_LEFT,
      MB_C_RIGHT,
      MB_V_LO,
      MB_V_HI
   } mb_sel_type;

   // Accumulator operations.
   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_INIT_Q30,
      ACC_INIT_Q40,
      ACC_ADD32,
      ACC_ADD64
   } acc_op_type;

   // Datapath register writes.
   typedef enum logic [3:0] {
      DST_NONE,
      DST_DIFF,
      DST_XL,
      DST_XR,
      DST_FL,
      DST_UPDATE,
      DST_PLOAD,
      DST_PX2,
      DST_PX4,
      DST_PF
   } dst_type;

   // Polynomial argument loads.
   typedef enum logic [1:0] {
      X_HOLD,
      X_XL,
      X_XR,
      X_MID
   } x_op_type;

   // One control word of the microprogram.
   typedef struct packed {
      seq_op_type seq_op;
      upc_type    target;
      ma_sel_type ma;
      mb_sel_type mb;
      acc_op_type acc_op;
      dst_type    dst;
      x_op_type   x_op;
   } uword_type;

   // Status returned to the sequencer.
   typedef struct packed {
      logic in_fire;
      logic out_free;
      logic cnt_zero;
   } status_type;

   function automatic uword_type gss_uw(input seq_op_type s, input upc_type t,
                                        input ma_sel_type ma, input mb_sel_type mb,
                                        input acc_op_type ac, input dst_type d,
                                        input x_op_type xo);
      uword_type w;
      w.seq_op = s;
      w.target = t;
      w.ma     = ma;
      w.mb     = mb;
      w.acc_op = ac;
      w.dst    = d;
      w.x_op   = xo;
      return w;
   endfunction

   // Microprogram. Multiplier products are registered, so each accumulate operation sits in
   // the step after the one that chose its operands.
   function automatic uword_type gss_urom(input upc_type pc);
      uword_type w;
      unique case (pc)
         // Wait for a beat, then narrow the interval until the count runs out.
         5'd0:  w = gss_uw(SEQ_WAIT_IN, UPC_IDLE, MA_DMAG, MB_C_LEFT, ACC_HOLD,
                          DST_NONE, X_HOLD);
         5'd1:  w = gss_uw(SEQ_JZ, UPC_FIN, MA_DMAG, MB_C_LEFT, ACC_HOLD,
                          DST_DIFF, X_HOLD);
         5'd2:  w = gss_uw(SEQ_NEXT, UPC_IDLE, MA_DMAG, MB_C_LEFT, ACC_HOLD,
                          DST_NONE, X_HOLD);
         5'd3:  w = gss_uw(SEQ_NEXT, UPC_IDLE, MA_DMAG, MB_C_RIGHT, ACC_INIT_Q30,
                          DST_NONE, X_HOLD);
         5'd4:  w = gss_uw(SEQ_NEXT, UPC_IDLE, MA_DMAG, MB_C_LEFT, ACC_INIT_Q30,
                          DST_XL, X_HOLD);
         5'd5:  w = gss_uw(SEQ_NEXT, UPC_IDLE, MA_DMAG, MB_C_LEFT, ACC_HOLD,
                          DST_XR, X_HOLD);
         5'd6:  w = gss_uw(SEQ_CALL, UPC_POLY, MA_DMAG, MB_C_LEFT, ACC_HOLD,
                          DST_NONE, X_XL);
         5'd7:  w = gss_uw(SEQ_CALL, UPC_POLY, MA_DMAG, MB_C_LEFT, ACC_HOLD,
                          DST_FL, X_XR);
         5'd8:  w = gss_uw(SEQ_JUMP, UPC_LOOP, MA_DMAG, MB_C_LEFT, ACC_HOLD,
                          DST_UPDATE, X_HOLD);
         // Evaluate at the midpoint and hand over the result.
         5'd9:  w = gss_uw(SEQ_CALL, UPC_POLY, MA_DMAG, MB_C_LEFT, ACC_HOLD,
                          DST_NONE, X_MID);
         5'd10: w = gss_uw(SEQ_WAIT_OUT, UPC_IDLE, MA_DMAG, MB_C_LEFT, ACC_HOLD,
                          DST_NONE, X_HOLD);
         // Polynomial subroutine: x^2, x^4 and x^5 as 64 by 64 products.
         5'd11: w = gss_uw(SEQ_NEXT, UPC_IDLE, MA_DMAG, MB_C_LEFT, ACC_HOLD,
                          DST_PLOAD, X_HOLD);
         5'd12: w = gss_uw(SEQ_NEXT, UPC_IDLE, MA_U_LO, MB_V_LO, ACC_HOLD,
                          DST_NONE, X_HOLD);
         5'd13: w = gss_uw(SEQ_NEXT, UPC_IDLE, MA_U_LO, MB_V_HI, ACC_INIT_Q40,
                          DST_NONE, X_HOLD);
         5'd14: w = gss_uw(SEQ_NEXT, UPC_IDLE, MA_U_HI, MB_V_LO, ACC_ADD32,
                          DST_NONE, X_HOLD);
         5'd15: w = gss_uw(SEQ_NEXT, UPC_IDLE, MA_U_HI, MB_V_HI, ACC_ADD32,
                          DST_NONE, X_HOLD);
         5'd16: w = gss_uw(SEQ_NEXT, UPC_IDLE, MA_DMAG, MB_C_LEFT, ACC_ADD64,
                          DST_NONE, X_HOLD);
         5'd17: w = gss_uw(SEQ_NEXT, UPC_IDLE, MA_DMAG, MB_C_LEFT, ACC_HOLD,
                          DST_PX2, X_HOLD);
         5'd18: w = gss_uw(SEQ_NEXT, UPC_IDLE, MA_U_LO, MB_V_LO, ACC_HOLD,
                          DST_NONE, X_HOLD);
         5'd19: w = gss_uw(SEQ_NEXT, UPC_IDLE, MA_U_LO, MB_V_HI, ACC_INIT_Q40,
                          DST_NONE, X_HOLD);
         5'd20: w = gss_uw(SEQ_NEXT, UPC_IDLE, MA_U_HI, MB_V_LO, ACC_ADD32,
                          DST_NONE, X_HOLD);
         5'd21: w = gss_uw(SEQ_NEXT, UPC_IDLE, MA_U_HI, MB_V_HI, ACC_ADD32,
                          DST_NONE, X_HOLD);
         5'd22: w = gss_uw(SEQ_NEXT, UPC_IDLE, MA_DMAG, MB_C_LEFT, ACC_ADD64,
                          DST_NONE, X_HOLD);
         5'd23: w = gss_uw(SEQ_NEXT, UPC_IDLE, MA_DMAG, MB_C_LEFT, ACC_HOLD,
                          DST_PX4, X_HOLD);
         5'd24: w = gss_uw(SEQ_NEXT, UPC_IDLE, MA_U_LO, MB_V_LO, ACC_HOLD,
                          DST_NONE, X_HOLD);
         5'd25: w = gss_uw(SEQ_NEXT, UPC_IDLE, MA_U_LO, MB_V_HI, ACC_INIT_Q40,
                          DST_NONE, X_HOLD);
         5'd26: w = gss_uw(SEQ_NEXT, UPC_IDLE, MA_U_HI, MB_V_LO, ACC_ADD32,
                          DST_NONE, X_HOLD);
         5'd27: w = gss_uw(SEQ_NEXT, UPC_IDLE, MA_U_HI, MB_V_HI, ACC_ADD32,
                          DST_NONE, X_HOLD);
         5'd28: w = gss_uw(SEQ_NEXT, UPC_IDLE, MA_DMAG, MB_C_LEFT, ACC_ADD64,
                          DST_NONE, X_HOLD);
         5'd29: w = gss_uw(SEQ_RET, UPC_IDLE, MA_DMAG, MB_C_LEFT, ACC_HOLD,
                          DST_PF, X_HOLD);
         default: w = gss_uw(SEQ_JUMP, UPC_IDLE, MA_DMAG, MB_C_LEFT, ACC_HOLD,
                            DST_NONE, X_HOLD);
      endcase
      return w;
   endfunction

endpackage

### src/golden_section_minimum_search_core.sv
// Top level of the golden-section minimum search core over x^5 + x^2 + 1.
// With N the step count clamped to MAX_STEPS, the core runs N narrowing steps, evaluates the
// polynomial at the midpoint and raises rsp_tvalid once the result register is free; the next
// request beat is taken only after that, so one search is in flight at a time. Every product
// goes through one 32 by 32 multiplier, four partial products for each 64-bit product.
// Synchronous reset returns the sequencer to idle and empties the result register.
module golden_section_minimum_search_core
   import gss_pkg::*;
#(
   parameter int MAX_STEPS = 64
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // left_bound [31:0], right_bound [63:32], step_count [70:64], zero [71]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // minimum_location [31:0], minimum_value [95:32]
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   uword_type             uword;
   status_type            status;
   logic                  in_fire;
   logic                  out_free;
   logic                  out_load;
   logic                  cnt_zero;
   logic signed [X_W-1:0] minimum_location;
   logic signed [F_W-1:0] minimum_value;

   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // Handshakes. No beat is taken while reset is held.
   assign req_tready = (uword.seq_op == SEQ_WAIT_IN) & ~reset;
   assign in_fire    = req_tvalid & req_tready;
   assign out_free   = ~rsp_tvalid_ff | rsp_tready;
   assign out_load   = (uword.seq_op == SEQ_WAIT_OUT) & out_free;

   gss_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .uword  (uword)
   );

   gss_dp #(
      .MAX_STEPS (MAX_STEPS)
   ) u_dp (
      .clock            (clock),
      .uword            (uword),
      .in_fire          (in_fire),
      .left_bound       ($signed(req_tdata[31:0])),
      .right_bound      ($signed(req_tdata[63:32])),
      .step_count       (req_tdata[70:64]),
      .cnt_zero         (cnt_zero),
      .minimum_location (minimum_location),
      .minimum_value    (minimum_value)
   );

   // Status bits for the sequencer, in the order of the status record.
   assign status = {in_fire, out_free, cnt_zero};

   // Result register: holds a finished beat while the next item is taken.
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (out_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {minimum_value, minimum_location};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

### src/gss_seq.sv
// Microcode sequencer: step counter, return link and control word ROM.
module gss_seq
   import gss_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output uword_type  uword
);

   upc_type pc_ff, pc_in;
   upc_type link_ff, link_in;
   upc_type pc_next;

   // Control word for the current step.
   assign uword   = gss_urom(pc_ff);
   assign pc_next = pc_ff + upc_type'(1);

   // Next step and return link.
   always_comb begin
      pc_in   = pc_next;
      link_in = link_ff;
      unique case (uword.seq_op)
         SEQ_NEXT:     pc_in = pc_next;
         SEQ_JUMP:     pc_in = uword.target;
         SEQ_JZ:       pc_in = status.cnt_zero ? uword.target : pc_next;
         SEQ_CALL: begin
            pc_in   = uword.target;
            link_in = pc_next;
         end
         SEQ_RET:      pc_in = link_ff;
         SEQ_WAIT_IN:  pc_in = status.in_fire ? pc_next : pc_ff;
         SEQ_WAIT_OUT: pc_in = status.out_free ? uword.target : pc_ff;
         default:      pc_in = UPC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= UPC_IDLE;
         link_ff <= UPC_IDLE;
      end else begin
         pc_ff   <= pc_in;
         link_ff <= link_in;
      end
   end

endmodule

### src/gss_mac.sv
// Shared 32 by 32 multiplier with a 128-bit rounding accumulator.
module gss_mac
   import gss_pkg::*;
(
   input  logic         clock,
   input  acc_op_type   acc_op,
   input  logic [31:0]  mul_a,
   input  logic [31:0]  mul_b,
   output logic [127:0] acc
);

   logic [63:0]  prod_ff, prod_in;
   logic [127:0] acc_ff, acc_in;

   localparam logic [127:0] RND_Q30 = 128'd1 << (Q30_SHIFT - 1);
   localparam logic [127:0] RND_Q40 = 128'd1 << (F_FRAC - 1);

   assign prod_in = mul_a * mul_b;
   assign acc     = acc_ff;

   // The first partial product enters with the rounding constant already added.
   always_comb begin
      case (acc_op)
         ACC_INIT_Q30: acc_in = {64'd0, prod_ff} + RND_Q30;
         ACC_INIT_Q40: acc_in = {64'd0, prod_ff} + RND_Q40;
         ACC_ADD32:    acc_in = acc_ff + {32'd0, prod_ff, 32'd0};
         ACC_ADD64:    acc_in = acc_ff + {prod_ff, 64'd0};
         default:      acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule

### src/gss_dp.sv
// Datapath: interval bounds, probes, polynomial registers and step count.
module gss_dp
   import gss_pkg::*;
#(
   parameter int MAX_STEPS = 64
)
(
   input  logic                  clock,
   input  uword_type             uword,
   input  logic                  in_fire,
   input  logic signed [X_W-1:0] left_bound,
   input  logic signed [X_W-1:0] right_bound,
   input  logic [STEP_W-1:0]     step_count,
   output logic                  cnt_zero,
   output logic signed [X_W-1:0] minimum_location,
   output logic signed [F_W-1:0] minimum_value
);

   localparam int CNT_W = $clog2(MAX_STEPS + 1);
   localparam int CMP_W = (CNT_W > STEP_W) ? CNT_W : STEP_W;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_STEPS);

   logic signed [X_W-1:0] a_ff, a_in, b_ff, b_in;
   logic signed [X_W:0]   d_ff, d_in;
   logic signed [X_W-1:0] xl_ff, xl_in, xr_ff, xr_in, x_ff, x_in;
   logic [63:0]           u_ff, u_in, v_ff, v_in, pos_ff, pos_in;
   logic                  neg_ff, neg_in, ovf_ff, ovf_in;
   logic signed [F_W-1:0] fl_ff, fl_in, f_ff, f_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   logic [CMP_W-1:0] step_ext;
   logic [X_W:0]     d_abs, x_ext, x_abs;
   logic [63:0]      m40;
   logic [31:0]      mul_a, mul_b;
   logic [127:0]     acc;
   logic [X_W:0]     scale_mag;
   logic [X_W+1:0]   scale_off, probe_sum;
   logic [63:0]      res;
   logic             res_ovf, ovf_all;
   logic [64:0]      pos_sum;
   logic [63:0]      pos_sat;
   logic [65:0]      f_sum;
   logic [63:0]      f_new;
   logic [X_W:0]     mid_sum;

   // Magnitudes of the interval width and of the polynomial argument.
   assign d_abs = d_ff[X_W] ? (~$unsigned(d_ff) + 33'd1) : $unsigned(d_ff);
   assign x_ext = {x_ff[X_W-1], x_ff};
   assign x_abs = x_ff[X_W-1] ? (~x_ext + 33'd1) : x_ext;
   assign m40   = {32'd0, x_abs[X_W-1:0]} << M40_SHIFT;

   // Multiplier operand selection.
   always_comb begin
      case (uword.ma)
         MA_DMAG: mul_a = d_abs[31:0];
         MA_U_LO: mul_a = u_ff[31:0];
         MA_U_HI: mul_a = u_ff[63:32];
         default: mul_a = '0;
      endcase
      case (uword.mb)
         MB_C_LEFT:  mul_b = ONE_MINUS_PHI_INV_Q30;
         MB_C_RIGHT: mul_b = PHI_INV_Q30;
         MB_V_LO:    mul_b = v_ff[31:0];
         MB_V_HI:    mul_b = v_ff[63:32];
         default:    mul_b = '0;
      endcase
   end

   gss_mac u_mac (
      .clock  (clock),
      .acc_op (uword.acc_op),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .acc    (acc)
   );

   // Probe: the rounded scaled width takes the sign of the width and is added to a.
   assign scale_mag = acc[Q30_SHIFT+X_W:Q30_SHIFT];
   assign scale_off = d_ff[X_W] ? (~{1'b0, scale_mag} + 34'd1) : {1'b0, scale_mag};
   assign probe_sum = {{2{a_ff[X_W-1]}}, a_ff} + scale_off;

   // Rounded Q40 product and its overflow flag.
   assign res     = acc[F_FRAC+63:F_FRAC];
   assign res_ovf = |acc[127:F_FRAC+64];
   assign ovf_all = ovf_ff | res_ovf;

   // One plus x squared, saturating.
   assign pos_sum = {1'b0, res} + {1'b0, ONE_Q40};
   assign pos_sat = pos_sum[64] ? '1 : pos_sum[63:0];

   // Final value: add or subtract x^5 and clamp to the signed 64-bit range.
   assign f_sum = neg_ff ? ({2'b00, pos_ff} - {2'b00, res}) : ({2'b00, pos_ff} + {2'b00, res});

   always_comb begin
      if (ovf_all) begin
         f_new = neg_ff ? F_MIN : F_MAX;
      end else if (f_sum[65:63] == 3'b000 || f_sum[65:63] == 3'b111) begin
         f_new = f_sum[63:0];
      end else begin
         f_new = f_sum[65] ? F_MIN : F_MAX;
      end
   end

   // Midpoint, rounded toward minus infinity.
   assign mid_sum  = {a_ff[X_W-1], a_ff} + {b_ff[X_W-1], b_ff};
   assign step_ext = CMP_W'(step_count);

   // Register updates.
   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      d_in   = d_ff;
      xl_in  = xl_ff;
      xr_in  = xr_ff;
      u_in   = u_ff;
      v_in   = v_ff;
      pos_in = pos_ff;
      neg_in = neg_ff;
      ovf_in = ovf_ff;
      fl_in  = fl_ff;
      f_in   = f_ff;
      cnt_in = cnt_ff;

      if (in_fire) begin
         a_in   = left_bound;
         b_in   = right_bound;
         cnt_in = (step_ext > MAX_CMP) ? MAX_CMP[CNT_W-1:0] : step_ext[CNT_W-1:0];
      end

      unique case (uword.dst)
         DST_NONE: begin
         end
         DST_DIFF: d_in = {b_ff[X_W-1], b_ff} - {a_ff[X_W-1], a_ff};
         DST_XL:   xl_in = $signed(probe_sum[X_W-1:0]);
         DST_XR:   xr_in = $signed(probe_sum[X_W-1:0]);
         DST_FL:   fl_in = f_ff;
         DST_UPDATE: begin
            if (fl_ff < f_ff) begin
               b_in = xr_ff;
            end else if (fl_ff > f_ff) begin
               a_in = xl_ff;
            end
            cnt_in = cnt_ff - CNT_W'(1);
         end
         DST_PLOAD: begin
            u_in   = m40;
            v_in   = m40;
            neg_in = x_ff[X_W-1];
            ovf_in = 1'b0;
         end
         DST_PX2: begin
            u_in   = res;
            v_in   = res;
            pos_in = pos_sat;
            ovf_in = ovf_all;
         end
         DST_PX4: begin
            u_in   = res;
            v_in   = m40;
            ovf_in = ovf_all;
         end
         DST_PF:   f_in = $signed(f_new);
         default: begin
         end
      endcase
   end

   // Polynomial argument.
   always_comb begin
      case (uword.x_op)
         X_XL:    x_in = xl_ff;
         X_XR:    x_in = xr_ff;
         X_MID:   x_in = $signed(mid_sum[X_W:1]);
         default: x_in = x_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      d_ff   <= d_in;
      xl_ff  <= xl_in;
      xr_ff  <= xr_in;
      x_ff   <= x_in;
      u_ff   <= u_in;
      v_ff   <= v_in;
      pos_ff <= pos_in;
      neg_ff <= neg_in;
      ovf_ff <= ovf_in;
      fl_ff  <= fl_in;
      f_ff   <= f_in;
      cnt_ff <= cnt_in;
   end

   assign cnt_zero         = (cnt_ff == '0);
   assign minimum_location = x_ff;
   assign minimum_value    = f_ff;

endmodule

### test/tb_golden_section_minimum_search_core.sv
// Self-checking testbench for the golden-section minimum search core.
`timescale 1ns / 100ps

import gss_pkg::*;

// Expected result of one search: midpoint and polynomial value there.
typedef struct packed {
   logic signed [X_W-1:0] location;
   logic signed [F_W-1:0] value;
} search_result_type;

// Scoreboard: predicts each search when its request beat is taken and checks result beats.
class search_scoreboard;
   search_result_type expected_results[$];
   int unsigned       error_count;
   int unsigned       checked_count;
   int unsigned       step_limit;

   function new(int unsigned limit);
      step_limit    = limit;
      error_count   = 0;
      checked_count = 0;
   endfunction

   function int unsigned pending();
      return expected_results.size();
   endfunction

   // One line per mismatch, and only the first 40 are printed.
   task report_mismatch(string text);
      error_count++;
      if (error_count <= 40) begin
         $display("MISMATCH at %0t: %s", $realtime, text);
      end
   endtask

   // Width times a Q30 constant, rounded to nearest with ties away from zero.
   function logic signed [63:0] probe_offset(logic signed [63:0] width, logic [31:0] coeff);
      logic        negative;
      logic [63:0] magnitude;
      logic [63:0] scaled;
      negative  = width < 0;
      magnitude = negative ? -width : width;
      scaled    = (magnitude * {32'd0, coeff} + (64'd1 << (Q30_SHIFT - 1))) >> Q30_SHIFT;
      return negative ? -scaled : scaled;
   endfunction

   // Q40 magnitude product rounded half up; an overflow sets the flag.
   function logic [63:0] q40_product(logic [63:0] u, logic [63:0] v, inout logic overflow);
      logic [127:0] full;
      full = {64'd0, u} * {64'd0, v} + (128'd1 << (F_FRAC - 1));
      if (full[127:64+F_FRAC] != '0) begin
         overflow = 1'b1;
         return '1;
      end
      return full[63+F_FRAC:F_FRAC];
   endfunction

   // x^5 + x^2 + 1 in Q23.40 with saturation, x in the Q3.28 format.
   function logic signed [63:0] poly_value(logic signed [63:0] x);
      logic        negative;
      logic        overflow;
      logic [63:0] magnitude;
      logic [63:0] m40;
      logic [63:0] x2;
      logic [63:0] x4;
      logic [63:0] x5;
      logic [63:0] diff;
      logic [64:0] positive;
      logic [64:0] total;
      negative  = x < 0;
      magnitude = negative ? -x : x;
      m40       = magnitude << M40_SHIFT;
      overflow  = 1'b0;
      x2 = q40_product(m40, m40, overflow);
      x4 = q40_product(x2, x2, overflow);
      x5 = q40_product(x4, m40, overflow);
      if (overflow) begin
         return negative ? F_MIN : F_MAX;
      end
      positive = {1'b0, x2} + {1'b0, ONE_Q40};
      if (positive[64]) begin
         positive = {1'b0, 64'hffff_ffff_ffff_ffff};
      end
      if (!negative) begin
         total = positive + {1'b0, x5};
         if (total[64] || total[63]) begin
            return F_MAX;
         end
         return total[63:0];
      end
      if (positive[63:0] >= x5) begin
         diff = positive[63:0] - x5;
         return diff[63] ? F_MAX : diff;
      end
      diff = x5 - positive[63:0];
      if (diff[63]) begin
         return F_MIN;
      end
      return -diff;
   endfunction

   // Runs the whole search for one accepted request and queues its result.
   function void note_request(logic signed [X_W-1:0] left, logic signed [X_W-1:0] right,
                              logic [STEP_W-1:0] steps);
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic signed [63:0] width;
      logic signed [63:0] xl;
      logic signed [63:0] xr;
      logic signed [63:0] fl;
      logic signed [63:0] fr;
      logic signed [63:0] mid;
      int unsigned        count;
      search_result_type  result;
      a     = left;
      b     = right;
      count = (steps > step_limit) ? step_limit : steps;
      for (int unsigned i = 0; i < count; i++) begin
         width = b - a;
         xl    = a + probe_offset(width, ONE_MINUS_PHI_INV_Q30);
         xr    = a + probe_offset(width, PHI_INV_Q30);
         fl    = poly_value(xl);
         fr    = poly_value(xr);
         // Equal values leave the interval as it is.
         if (fl < fr) begin
            b = xr;
         end else if (fl > fr) begin
            a = xl;
         end
      end
      // Arithmetic shift gives the midpoint rounded toward negative infinity.
      mid             = (a + b) >>> 1;
      result.location = mid[X_W-1:0];
      result.value    = poly_value(mid);
      expected_results.push_back(result);
   endfunction

   // Compares one result beat with the oldest prediction.
   task check_result(logic [RSP_TDATA_W-1:0] beat);
      search_result_type wanted;
      logic [X_W-1:0]    got_location;
      logic [F_W-1:0]    got_value;
      got_location = beat[X_W-1:0];
      got_value    = beat[X_W+F_W-1:X_W];
      if (expected_results.size() == 0) begin
         report_mismatch($sformatf("result beat %h with no search outstanding", beat));
         return;
      end
      wanted = expected_results.pop_front();
      checked_count++;
      if (got_location !== wanted.location) begin
         report_mismatch($sformatf("result %0d: minimum_location %h, expected %h",
                                   checked_count, got_location, wanted.location));
      end
      if (got_value !== wanted.value) begin
         report_mismatch($sformatf("result %0d: minimum_value %h, expected %h",
                                   checked_count, got_value, wanted.value));
      end
   endtask
endclass

module tb_golden_section_minimum_search_core;

   localparam int unsigned STEP_LIMIT      = 64;
   localparam int unsigned PHASE_ITEMS     = 150;
   localparam int unsigned HOLD_OFF_CYCLES = 6000;
   localparam int unsigned DRAIN_LIMIT     = 20000;
   localparam int unsigned SETTLE_CYCLES   = 100;

   localparam logic signed [X_W-1:0] X_MIN = 32'sh8000_0000;
   localparam logic signed [X_W-1:0] X_MAX = 32'sh7fff_ffff;
   localparam logic signed [X_W-1:0] X_ONE = 32'sh1000_0000;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   logic             hold_off    = 1'b0;
   int unsigned      idle_pct    = 0;
   int unsigned      stall_pct   = 0;
   int unsigned      sent_count  = 0;
   int unsigned      clamp_count = 0;
   int unsigned      rev_count   = 0;
   search_scoreboard board;

   golden_section_minimum_search_core #(
      .MAX_STEPS (STEP_LIMIT)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: check each accepted beat and choose the next ready level.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            board.check_result(rsp_tdata);
         end
         rsp_tready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Offers one request beat after a random gap and waits until it is taken.
   task send_request(logic signed [X_W-1:0] left, logic signed [X_W-1:0] right,
                     logic [STEP_W-1:0] steps);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      // Fields from the lowest bit: left_bound, right_bound, step_count, zero pad.
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, steps, right, left};
      do begin
         @(posedge clock);
      end while (!req_tready);
      board.note_request(left, right, steps);
      sent_count++;
      if (steps > STEP_LIMIT) begin
         clamp_count++;
      end
      if (right < left) begin
         rev_count++;
      end
   endtask

   // Random request: mostly ordered intervals of many widths, some reversed or full noise.
   task send_random_request();
      longint lo;
      longint hi;
      longint tmp;
      int     kind;
      int     pick;
      int     steps;
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         lo = longint'(int'($urandom));
         hi = longint'(int'($urandom));
      end else if (kind < 18) begin
         lo = longint'(int'($urandom) >>> $urandom_range(0, 31));
         hi = lo + $urandom_range(0, 3);
      end else begin
         lo = longint'(int'($urandom) >>> $urandom_range(0, 6));
         hi = lo + (longint'($urandom) >> $urandom_range(0, 31));
      end
      if (hi > longint'(X_MAX)) begin
         hi = longint'(X_MAX);
      end
      if (kind >= 10 && $urandom_range(0, 99) < 12) begin
         tmp = lo;
         lo  = hi;
         hi  = tmp;
      end
      // Long searches are slow, so most requests use few steps.
      pick = $urandom_range(0, 99);
      if (pick < 90) begin
         steps = $urandom_range(0, 12);
      end else if (pick < 97) begin
         steps = $urandom_range(13, 63);
      end else begin
         steps = $urandom_range(64, 127);
      end
      send_request(lo[X_W-1:0], hi[X_W-1:0], steps[STEP_W-1:0]);
   endtask

   // Main sequence: reset, directed requests, random phases, drain.
   initial begin
      int unsigned drain;
      board = new(STEP_LIMIT);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero steps, full range, step clamping, reversed and degenerate intervals.
      send_request(0, 0, 0);
      send_request(X_MIN, X_MAX, 0);
      send_request(X_MIN, X_MAX, 64);
      send_request(X_MIN, X_MAX, 127);
      send_request(-X_ONE, X_ONE, 65);
      send_request(-X_ONE, X_ONE, 20);
      send_request(X_ONE / 2, 3 * X_ONE, 30);
      send_request(-2 * X_ONE, -X_ONE / 8, 40);
      send_request(X_MAX, X_MIN, 12);
      send_request(X_ONE, -X_ONE, 25);
      send_request(12345, 12345, 5);
      send_request(5, 7, 8);
      send_request(-100, 100, 16);
      send_request(-1, 0, 3);
      send_request(X_MAX - 1, X_MAX, 4);
      send_request(X_MIN, X_MIN + 3, 4);
      send_request(X_MIN, -X_ONE, 64);
      send_request(32'shaaaa_aaaa, 32'sh5555_5555, 1);
      send_request(32'sh5555_5555, 32'shaaaa_aaaa, 2);
      send_request(0, X_ONE, 1);
      send_request(0, X_ONE, 2);

      // Random phases with different idling on both sides.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 63;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 63;
            end
            3: begin
               idle_pct  = 13;
               stall_pct = 13;
            end
            default: begin
               idle_pct  = 0;
               stall_pct = 0;
               // Long receiver hold-off while requests keep coming, so the input stalls.
               fork
                  begin
                     hold_off <= 1'b1;
                     repeat (HOLD_OFF_CYCLES) @(posedge clock);
                     hold_off <= 1'b0;
                  end
               join_none
            end
         endcase
         for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
            send_random_request();
         end
      end
      req_tvalid <= 1'b0;

      // Wait for the outstanding results, then a little longer for stray beats.
      drain = 0;
      while (board.pending() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      if (board.pending() != 0) begin
         board.report_mismatch($sformatf("%0d expected results never arrived",
                                         board.pending()));
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d searches (%0d with clamped step counts, %0d reversed intervals),",
               sent_count, clamp_count, rev_count);
      $display("checked %0d results over five idling phases and one receiver hold-off.",
               board.checked_count);
      if (board.error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #200_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
